/* src/assert_macros.svh */
// assertion macros shared by the resize block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define IPR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define IPR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/ipr_pkg.sv */
// shared types, constants and codes of the image plane resize block
`default_nettype none

package ipr_pkg;

    localparam int IDX_W      = 8;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int SIZE_W     = 9;
    localparam int SCALE_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int PROD_W     = SIZE_W + SCALE_W;
    localparam int FIX_W      = PROD_W + 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [SIZE_W-1:0] MAX_HEIGHT = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] MAX_WIDTH  = SIZE_W'(256);
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << FRAC_W;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic INTERP_NEAREST  = 1'b0;
    localparam logic INTERP_BILINEAR = 1'b1;

    localparam logic [1:0] RULE_CENTERED   = 2'd0;
    localparam logic [1:0] RULE_ASYMMETRIC = 2'd1;
    localparam logic [1:0] RULE_PYTORCH    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT   = 3'd0,
        CFG_IN_WIDTH    = 3'd1,
        CFG_OUT_HEIGHT  = 3'd2,
        CFG_OUT_WIDTH   = 3'd3,
        CFG_INTERP_MODE = 3'd4,
        CFG_COORD_RULE  = 3'd5,
        CFG_SCALE_H     = 3'd6,
        CFG_SCALE_W     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  in_height;
        logic [SIZE_W-1:0]  in_width;
        logic [SIZE_W-1:0]  out_height;
        logic [SIZE_W-1:0]  out_width;
        logic               interp_mode;
        logic [1:0]         coord_rule;
        logic [SCALE_W-1:0] scale_h;
        logic [SCALE_W-1:0] scale_w;
    } cfg_t;

    // one command for the store side: a load or a resolved pixel fetch
    typedef struct packed {
        logic                       is_load;
        logic                       bilin;
        logic [IDX_W-1:0]           h0;
        logic [IDX_W-1:0]           h1;
        logic [IDX_W-1:0]           w0;
        logic [IDX_W-1:0]           w1;
        logic [FRAC_W-1:0]          dh;
        logic [FRAC_W-1:0]          dw;
        logic signed [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } fifo_stat_t;

endpackage

`default_nettype wire

/* src/ipr_req_if.sv */
// request channel interface: mode, row, column and sample
`default_nettype none

interface ipr_req_if import ipr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output mode, output row, output col, output sample,
                    input ready);
    modport sink (input valid, input mode, input row, input col, input sample,
                  output ready);
endinterface

`default_nettype wire

/* src/ipr_pix_if.sv */
// result channel interface: one output pixel
`default_nettype none

interface ipr_pix_if import ipr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

/* src/ipr_front.sv */
// front end: takes requests, maps output coordinates onto the source plane
`default_nettype none

module ipr_front import ipr_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ipr_req_if.sink         req,
    input  wire cfg_t       cfg,
    input  wire fifo_stat_t qstat,
    output logic            push,
    output cmd_t            push_cmd
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

    typedef struct packed {
        logic [IDX_W-1:0]  i0;
        logic [IDX_W-1:0]  i1;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    localparam logic [FIX_W-1:0] ONE_FIX  = FIX_W'(1) << FRAC_W;
    localparam logic [FIX_W-1:0] HALF_FIX = FIX_W'(1) << (FRAC_W - 1);

    fstate_t                    state_reg;
    logic                       mode_reg;
    logic [IDX_W-1:0]           row_reg;
    logic [IDX_W-1:0]           col_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [PROD_W-1:0]          prod_h_reg;
    logic [PROD_W-1:0]          prod_w_reg;
    logic                       hit_reg;
    logic [SIZE_W-1:0]          mult_h;
    logic [SIZE_W-1:0]          mult_w;
    logic                       wanted;
    axis_t                      axis_h;
    axis_t                      axis_w;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size,
                                                   input logic [SIZE_W-1:0] max_size);
        if (size == '0)
            return SIZE_W'(1);
        else if (size > max_size)
            return max_size;
        else
            return size;
    endfunction

    function automatic axis_t resolve_axis(input logic [PROD_W-1:0] prod,
                                           input logic [1:0]        rule,
                                           input logic [SIZE_W-1:0] out_size,
                                           input logic [SIZE_W-1:0] size,
                                           input logic              bilin);
        logic signed [FIX_W-1:0] f;
        logic signed [FIX_W-1:0] t;
        logic signed [FIX_W-1:0] size_s;
        logic signed [FIX_W-1:0] last_s;
        logic [IDX_W-1:0]        last;
        axis_t                   a;
        if (rule == RULE_ASYMMETRIC)
            f = $signed(FIX_W'(prod));
        else if (rule == RULE_PYTORCH && out_size <= SIZE_W'(1))
            f = '0;
        else
            f = ($signed(FIX_W'(prod)) - $signed(ONE_FIX)) >>> 1;
        last   = IDX_W'(size - SIZE_W'(1));
        size_s = $signed(FIX_W'(size));
        last_s = $signed(FIX_W'(last));
        a      = '0;
        if (bilin == INTERP_NEAREST)
        begin
            // round half up, then clamp into the plane
            t = (f + $signed(HALF_FIX)) >>> FRAC_W;
            if (t < 0)
                a.i0 = '0;
            else if (t >= size_s)
                a.i0 = last;
            else
                a.i0 = t[IDX_W-1:0];
            a.i1 = a.i0;
        end
        else
        begin
            t = f >>> FRAC_W;
            if (t < 0)
                a = '0;
            else if (t >= last_s)
            begin
                a.i0 = last;
                a.i1 = last;
            end
            else
            begin
                a.i0   = t[IDX_W-1:0];
                a.i1   = t[IDX_W-1:0] + IDX_W'(1);
                a.frac = f[FRAC_W-1:0];
            end
        end
        return a;
    endfunction

    assign req.ready = (state_reg == F_IDLE);

    // centered rules need (2o+1)*s, asymmetric needs o*s
    assign mult_h = (cfg.coord_rule == RULE_ASYMMETRIC) ? {1'b0, row_reg} : {row_reg, 1'b1};
    assign mult_w = (cfg.coord_rule == RULE_ASYMMETRIC) ? {1'b0, col_reg} : {col_reg, 1'b1};

    assign axis_h = resolve_axis(prod_h_reg, cfg.coord_rule, cfg.out_height,
                                 eff_size(cfg.in_height, MAX_HEIGHT), cfg.interp_mode);
    assign axis_w = resolve_axis(prod_w_reg, cfg.coord_rule, cfg.out_width,
                                 eff_size(cfg.in_width, MAX_WIDTH), cfg.interp_mode);

    assign wanted = (mode_reg == MODE_LOAD) || hit_reg;
    assign push   = (state_reg == F_PUSH) && wanted && !qstat.full;

    always_comb
    begin
        push_cmd        = '0;
        push_cmd.sample = sample_reg;
        if (mode_reg == MODE_LOAD)
        begin
            push_cmd.is_load = 1'b1;
            push_cmd.h0      = row_reg;
            push_cmd.w0      = col_reg;
        end
        else
        begin
            push_cmd.bilin = cfg.interp_mode;
            push_cmd.h0    = axis_h.i0;
            push_cmd.h1    = axis_h.i1;
            push_cmd.dh    = axis_h.frac;
            push_cmd.w0    = axis_w.i0;
            push_cmd.w1    = axis_w.i1;
            push_cmd.dw    = axis_w.frac;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            mode_reg   <= MODE_LOAD;
            row_reg    <= '0;
            col_reg    <= '0;
            sample_reg <= '0;
            prod_h_reg <= '0;
            prod_w_reg <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg   <= req.mode;
                        row_reg    <= req.row;
                        col_reg    <= req.col;
                        sample_reg <= req.sample;
                        state_reg  <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    prod_h_reg <= PROD_W'(mult_h * cfg.scale_h);
                    prod_w_reg <= PROD_W'(mult_w * cfg.scale_w);
                    hit_reg    <= ({1'b0, row_reg} < cfg.out_height) &&
                                  ({1'b0, col_reg} < cfg.out_width);
                    state_reg  <= F_PUSH;
                end
                F_PUSH:
                begin
                    // requests outside the output plane are dropped here
                    if (!wanted || !qstat.full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/ipr_cmd_fifo.sv */
// short command queue between the front end and the store side
`default_nettype none

module ipr_cmd_fifo import ipr_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire cmd_t   push_cmd,
    input  wire logic   pop,
    output cmd_t        head,
    output fifo_stat_t  stat
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

/* src/ipr_back.sv */
// back end: plane store, neighbour fetch, interpolation and output register
`default_nettype none

module ipr_back import ipr_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       head,
    input  wire fifo_stat_t qstat,
    output logic            pop,
    ipr_pix_if.source       pix
);

    typedef enum logic [3:0] {
        B_IDLE, B_RD1, B_RD2, B_RD3, B_RD4, B_MULA, B_SUMA, B_MULB, B_DONE
    } bstate_t;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int MPROD_W = DIFF_W + FRAC_W + 1;

    logic signed [SAMPLE_W-1:0] plane_mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]          mem_addr;
    logic                       mem_we;

    bstate_t                    state_reg;
    cmd_t                       cur_reg;
    logic signed [SAMPLE_W-1:0] v00_reg;
    logic signed [SAMPLE_W-1:0] v01_reg;
    logic signed [SAMPLE_W-1:0] v10_reg;
    logic signed [SAMPLE_W-1:0] v0_reg;
    logic signed [SAMPLE_W-1:0] v1_reg;
    logic signed [MPROD_W-1:0]  p0_reg;
    logic signed [MPROD_W-1:0]  p1_reg;
    logic signed [MPROD_W-1:0]  p2_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_pixel_reg;

    logic signed [DIFF_W-1:0]   diff0;
    logic signed [DIFF_W-1:0]   diff1;
    logic signed [DIFF_W-1:0]   diff2;
    logic                       out_load;

    assign pop    = (state_reg == B_IDLE) && !qstat.empty;
    assign mem_we = pop && head.is_load;

    // single store port: idle reads the first neighbour of the head command
    always_comb
    begin
        case (state_reg)
            B_IDLE:  mem_addr = {head.h0, head.w0};
            B_RD1:   mem_addr = {cur_reg.h0, cur_reg.w1};
            B_RD2:   mem_addr = {cur_reg.h1, cur_reg.w0};
            B_RD3:   mem_addr = {cur_reg.h1, cur_reg.w1};
            default: mem_addr = {cur_reg.h0, cur_reg.w0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            plane_mem[mem_addr] <= head.sample;
        rdata_reg <= plane_mem[mem_addr];
    end

    assign diff0 = DIFF_W'(v01_reg) - DIFF_W'(v00_reg);
    assign diff1 = DIFF_W'(rdata_reg) - DIFF_W'(v10_reg);
    assign diff2 = DIFF_W'(v1_reg) - DIFF_W'(v0_reg);

    assign out_load  = (state_reg == B_DONE) && (!out_valid_reg || pix.ready);
    assign pix.valid = out_valid_reg;
    assign pix.pixel = out_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cur_reg       <= '0;
            v00_reg       <= '0;
            v01_reg       <= '0;
            v10_reg       <= '0;
            v0_reg        <= '0;
            v1_reg        <= '0;
            p0_reg        <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_pixel_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_pixel_reg <= v0_reg + SAMPLE_W'(p2_reg >>> FRAC_W);
            end
            else if (pix.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (pop && !head.is_load)
                    begin
                        cur_reg   <= head;
                        state_reg <= B_RD1;
                    end
                end
                B_RD1:
                begin
                    if (cur_reg.bilin == INTERP_BILINEAR)
                    begin
                        v00_reg   <= rdata_reg;
                        state_reg <= B_RD2;
                    end
                    else
                    begin
                        v0_reg    <= rdata_reg;
                        p2_reg    <= '0;
                        state_reg <= B_DONE;
                    end
                end
                B_RD2:
                begin
                    v01_reg   <= rdata_reg;
                    state_reg <= B_RD3;
                end
                B_RD3:
                begin
                    v10_reg   <= rdata_reg;
                    state_reg <= B_RD4;
                end
                B_RD4:
                begin
                    // last neighbour arrives: both horizontal products at once
                    p0_reg    <= diff0 * $signed({1'b0, cur_reg.dw});
                    p1_reg    <= diff1 * $signed({1'b0, cur_reg.dw});
                    state_reg <= B_MULA;
                end
                B_MULA:
                begin
                    v0_reg    <= v00_reg + SAMPLE_W'(p0_reg >>> FRAC_W);
                    v1_reg    <= v10_reg + SAMPLE_W'(p1_reg >>> FRAC_W);
                    state_reg <= B_SUMA;
                end
                B_SUMA:
                begin
                    p2_reg    <= diff2 * $signed({1'b0, cur_reg.dh});
                    state_reg <= B_MULB;
                end
                B_MULB:
                begin
                    state_reg <= B_DONE;
                end
                B_DONE:
                begin
                    if (out_load)
                        state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/image_plane_resize.sv */
// image_plane_resize top level: config registers, front end, queue and store side
// Resizes one image plane held in an on-chip 256 x 256 store of signed samples.
// req channel: mode 0 writes sample at (row, col) of the store, mode 1 asks for
// the output pixel at output (row, col). pix channel returns one pixel for each
// request inside out_height x out_width; other requests and loads return nothing.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// The front end takes no new request until it has pushed or dropped the last
// one; the store side finishes each command before it pops the next, a bilinear
// pixel taking the four neighbour reads through the single store port and the two
// registered interpolation multiplies. A 4-entry queue sits between the two.
// Reset clears the registers to sizes 1, nearest, centered sampling, scales 1.0
// and empties the queue; store contents are undefined until written.
// A stalled pix receiver holds the result in the output register and the store
// side waits behind it; loads and requests queue up until the queue fills, then
// req.ready drops.
`default_nettype none
`include "assert_macros.svh"

module image_plane_resize import ipr_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ipr_req_if.sink                    req,
    ipr_pix_if.source                  pix,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       q_push;
    logic       q_pop;
    cmd_t       q_push_cmd;
    cmd_t       q_head;
    fifo_stat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_height   <= SIZE_W'(1);
            cfg_reg.in_width    <= SIZE_W'(1);
            cfg_reg.out_height  <= SIZE_W'(1);
            cfg_reg.out_width   <= SIZE_W'(1);
            cfg_reg.interp_mode <= INTERP_NEAREST;
            cfg_reg.coord_rule  <= RULE_CENTERED;
            cfg_reg.scale_h     <= SCALE_ONE;
            cfg_reg.scale_w     <= SCALE_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IN_HEIGHT:   cfg_reg.in_height   <= cfg_data[SIZE_W-1:0];
                CFG_IN_WIDTH:    cfg_reg.in_width    <= cfg_data[SIZE_W-1:0];
                CFG_OUT_HEIGHT:  cfg_reg.out_height  <= cfg_data[SIZE_W-1:0];
                CFG_OUT_WIDTH:   cfg_reg.out_width   <= cfg_data[SIZE_W-1:0];
                CFG_INTERP_MODE: cfg_reg.interp_mode <= cfg_data[0];
                CFG_COORD_RULE:  cfg_reg.coord_rule  <= cfg_data[1:0];
                CFG_SCALE_H:     cfg_reg.scale_h     <= cfg_data[SCALE_W-1:0];
                CFG_SCALE_W:     cfg_reg.scale_w     <= cfg_data[SCALE_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    ipr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg_reg),
        .qstat    (q_stat),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    ipr_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    ipr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .qstat (q_stat),
        .pop   (q_pop),
        .pix   (pix)
    );

    `IPR_ASSERT_IMPL(a_no_push_full, q_push, !q_stat.full, "command pushed into a full queue")
    `IPR_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_stat.empty, "command popped from an empty queue")
    `IPR_ASSERT_ALWAYS(a_count_range, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

`default_nettype wire
